// ===== rtl/assert_macros.svh =====
// Assertion macros of the buffer cache manager, used by its top-level RTL file.
// Depends on nothing; simulation builds get the checks, synthesis gets empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BBCM_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define BBCM_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define BBCM_ASSERT(label, clk, rst_n, prop)
`define BBCM_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== rtl/bbcm_pkg.sv =====
// Types and codes of the block buffer cache manager.
// Depends on nothing; used by the interfaces and all modules.
package bbcm_pkg;
	typedef enum logic [1:0] {
		K_GET     = 2'd0,
		K_READ    = 2'd1,
		K_RELEASE = 2'd2,
		K_WRITE   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_WAIT = 2'd1,
		ST_BAD  = 2'd2,
		ST_OVF  = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  device;
		logic [31:0] block_number;
		logic [3:0]  buffer_index;
		logic        modified;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  handle;
		logic        was_hit;
		logic        read_request;
		logic        write_request;
		logic [7:0]  request_device;
		logic [32:0] request_sector;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic lookup;
		logic commit;
	} cmd_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOK,
		S_COMMIT
	} state_t;
endpackage

// ===== rtl/bbcm_req_if.sv =====
// Request channel of the buffer cache manager.
// Depends on bbcm_pkg for the payload type.
interface bbcm_req_if;
	import bbcm_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/bbcm_rsp_if.sv =====
// Response channel of the buffer cache manager.
// Depends on bbcm_pkg for the payload type.
interface bbcm_rsp_if;
	import bbcm_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/bbcm_ctrl.sv =====
// Sequencer of the buffer cache manager: capture, tag lookup, commit.
// Depends on bbcm_pkg for the state and command types.
module bbcm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output bbcm_pkg::cmd_t cmd
);
	import bbcm_pkg::*;

	state_t state_q, state_n;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_n = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_n = S_LOOK;
				end
			end
			S_LOOK: begin
				cmd.lookup = 1'b1;
				state_n = S_COMMIT;
			end
			S_COMMIT: begin
				// The result register must be free before it is overwritten.
				if (!out_valid_q || out_ready) begin
					cmd.commit = 1'b1;
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;
endmodule

// ===== rtl/bbcm_dp.sv =====
// Datapath of the buffer cache manager: tag store, counts, flags, free list, result register.
// Depends on bbcm_pkg; driven by commands from bbcm_ctrl.
module bbcm_dp #(
	parameter int NUM_BUFFERS = 16,
	parameter int SECTORS_PER_BLOCK = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  bbcm_pkg::cmd_t cmd,
	input  bbcm_pkg::req_t in_data,
	output bbcm_pkg::rsp_t out_data
);
	import bbcm_pkg::*;

	localparam int IW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
	localparam int CW = $clog2(NUM_BUFFERS + 1);

	logic [7:0]  tag_dev_q [NUM_BUFFERS];
	logic [31:0] tag_blk_q [NUM_BUFFERS];
	logic [7:0]  cnt_q [NUM_BUFFERS];
	logic [IW-1:0] fo_q [NUM_BUFFERS];
	logic [NUM_BUFFERS-1:0] dirty_q, valid_q, mapped_q;
	logic [CW-1:0] alloc_q, flen_q;

	req_t in_q;
	rsp_t rsp_q, rsp_n;
	logic hit_s1;
	logic [IW-1:0] hit_idx_s1;

	logic hit_c;
	logic [IW-1:0] hit_idx_c, hit_pos, tgt, remove_pos;
	logic do_new, do_inc, do_dec, do_read, do_write, push_en, remove_en;
	logic [7:0]  rq_dev;
	logic [31:0] rq_blk;

	// Parallel tag compare, lowest matching buffer wins.
	always_comb begin
		hit_c = 1'b0;
		hit_idx_c = '0;
		for (int i = NUM_BUFFERS - 1; i >= 0; i--) begin
			if (mapped_q[i] && tag_dev_q[i] == in_q.device && tag_blk_q[i] == in_q.block_number)
			begin
				hit_c = 1'b1;
				hit_idx_c = IW'(i);
			end
		end
	end

	// Position of the hit buffer in the free list.
	always_comb begin
		hit_pos = '0;
		for (int i = NUM_BUFFERS - 1; i >= 0; i--) begin
			if (i < int'(flen_q) && fo_q[i] == hit_idx_s1) hit_pos = IW'(i);
		end
	end

	always_comb begin
		rsp_n = '0;
		tgt = '0;
		do_new = 1'b0;
		do_inc = 1'b0;
		do_dec = 1'b0;
		do_read = 1'b0;
		do_write = 1'b0;
		push_en = 1'b0;
		remove_en = 1'b0;
		remove_pos = '0;
		rq_dev = '0;
		rq_blk = '0;
		if (in_q.kind == K_GET || in_q.kind == K_READ) begin
			if (hit_s1) begin
				tgt = hit_idx_s1;
				rsp_n.handle = 4'(hit_idx_s1);
				rsp_n.was_hit = 1'b1;
				if (cnt_q[tgt] == 8'hFF) begin
					rsp_n.status = ST_OVF;
				end else begin
					do_inc = 1'b1;
					if (cnt_q[tgt] == 8'd0) begin
						remove_en = 1'b1;
						remove_pos = hit_pos;
					end
					if (in_q.kind == K_READ && !valid_q[tgt]) do_read = 1'b1;
				end
			end else if (alloc_q < CW'(NUM_BUFFERS)) begin
				tgt = IW'(alloc_q);
				do_new = 1'b1;
			end else if (flen_q != '0) begin
				tgt = fo_q[0];
				do_new = 1'b1;
				remove_en = 1'b1;
			end else begin
				rsp_n.status = ST_WAIT;
			end
			if (do_new) begin
				rsp_n.handle = 4'(tgt);
				if (in_q.kind == K_READ) do_read = 1'b1;
			end
			if (do_read) begin
				rq_dev = do_new ? in_q.device : tag_dev_q[tgt];
				rq_blk = do_new ? in_q.block_number : tag_blk_q[tgt];
			end
		end else begin
			rsp_n.handle = in_q.buffer_index;
			tgt = IW'(in_q.buffer_index);
			if (32'(in_q.buffer_index) >= NUM_BUFFERS) begin
				rsp_n.status = ST_BAD;
			end else if (cnt_q[tgt] == 8'd0) begin
				rsp_n.status = ST_BAD;
			end else begin
				do_write = dirty_q[tgt] | in_q.modified;
				if (in_q.kind == K_RELEASE) begin
					do_dec = 1'b1;
					push_en = (cnt_q[tgt] == 8'd1) && (flen_q < CW'(NUM_BUFFERS));
				end
				if (do_write) begin
					rq_dev = tag_dev_q[tgt];
					rq_blk = tag_blk_q[tgt];
				end
			end
		end
		rsp_n.read_request = do_read;
		rsp_n.write_request = do_write;
		rsp_n.request_device = rq_dev;
		rsp_n.request_sector = 33'({1'b0, rq_blk} * 33'(SECTORS_PER_BLOCK));
	end

	// Payload registers: no reset needed.
	always_ff @(posedge clk) begin
		if (cmd.load) in_q <= in_data;
		if (cmd.lookup) begin
			hit_s1 <= hit_c;
			hit_idx_s1 <= hit_idx_c;
		end
		if (cmd.commit) begin
			rsp_q <= rsp_n;
			if (do_new) begin
				tag_dev_q[tgt] <= in_q.device;
				tag_blk_q[tgt] <= in_q.block_number;
			end
			if (remove_en) begin
				for (int i = 0; i < NUM_BUFFERS - 1; i++) begin
					if (IW'(i) >= remove_pos) fo_q[i] <= fo_q[i + 1];
				end
			end
			if (push_en) fo_q[IW'(flen_q)] <= tgt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BUFFERS; i++) cnt_q[i] <= '0;
			dirty_q <= '0;
			valid_q <= '0;
			mapped_q <= '0;
			alloc_q <= '0;
			flen_q <= '0;
		end else if (cmd.commit) begin
			if (do_new) begin
				mapped_q[tgt] <= 1'b1;
				valid_q[tgt] <= 1'b0;
				dirty_q[tgt] <= 1'b0;
				cnt_q[tgt] <= 8'd1;
				if (!remove_en) alloc_q <= alloc_q + 1'b1;
			end
			if (do_inc) cnt_q[tgt] <= cnt_q[tgt] + 8'd1;
			if (do_dec) cnt_q[tgt] <= cnt_q[tgt] - 8'd1;
			if (do_read || do_write) begin
				dirty_q[tgt] <= 1'b0;
				valid_q[tgt] <= 1'b1;
			end
			if (remove_en) flen_q <= flen_q - 1'b1;
			else if (push_en) flen_q <= flen_q + 1'b1;
		end
	end

	assign out_data = rsp_q;
endmodule

// ===== rtl/block_buffer_cache_manager.sv =====
// Block buffer cache manager: a pool of NUM_BUFFERS buffers with least recently released
// replacement. The accepting edge captures the request, the lookup state registers the
// parallel tag compare over all buffers, and the commit state updates the counts, flags and
// free list and loads the result register. The result is valid from then on, and the
// controller is back in idle, so the next request can be accepted; none is taken while one
// is in lookup or commit. A new request is taken while an earlier result still waits in the
// output register, but its commit stalls until that result has been taken. Release and write
// answer status bad for out-of-range handles or handles with a zero count; get or read
// answer overflow when the hit buffer's count is at its maximum, and wait when no buffer
// is free.
// Depends on bbcm_pkg, the channel interfaces, bbcm_ctrl and bbcm_dp.
`include "assert_macros.svh"
module block_buffer_cache_manager #(
	parameter int NUM_BUFFERS = 16,
	parameter int SECTORS_PER_BLOCK = 2
) (
	input logic      clk,
	input logic      arst_n,
	bbcm_req_if.sink req,
	bbcm_rsp_if.source rsp
);
	import bbcm_pkg::*;

	cmd_t cmd;

	bbcm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	bbcm_dp #(
		.NUM_BUFFERS       (NUM_BUFFERS),
		.SECTORS_PER_BLOCK (SECTORS_PER_BLOCK)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (req.data),
		.out_data (rsp.data)
	);

	`BBCM_ASSERT(a_one_at_a_time, clk, arst_n, (req.valid && req.ready) |=> !req.ready)
	`BBCM_NEVER(a_single_request, clk, arst_n,
		rsp.valid && rsp.data.read_request && rsp.data.write_request)
	`BBCM_ASSERT(a_wait_quiet, clk, arst_n,
		(rsp.valid && rsp.data.status == ST_WAIT) |->
		(!rsp.data.was_hit && !rsp.data.read_request && !rsp.data.write_request))
endmodule

// ===== tb/block_buffer_cache_manager_test.sv =====
// Self-checking test of the block buffer cache manager: random and directed transactions
// with a behavioral predictor of the buffer pool. Depends on bbcm_pkg and the channel interfaces.
module block_buffer_cache_manager_test;
	timeunit 1ns;
	timeprecision 1ps;
	import bbcm_pkg::*;

	localparam int NBUF = 16;
	localparam int SPB = 2;
	localparam int LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bbcm_req_if req ();
	bbcm_rsp_if rsp ();

	block_buffer_cache_manager #(.NUM_BUFFERS(NBUF), .SECTORS_PER_BLOCK(SPB)) i_dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source)
	);

	always #10 clk = ~clk;

	// Predictor state of the buffer pool.
	logic [7:0]  pool_dev [NBUF];
	logic [31:0] pool_blk [NBUF];
	logic [7:0]  pool_refs [NBUF];
	logic        pool_dirty [NBUF];
	logic        pool_valid [NBUF];
	logic        pool_mapped [NBUF];
	int          used_count;
	int          lru_list [$];

	req_t pending_reqs [$];
	rsp_t expected_rsps [$];
	int errors = 0;
	int cycles = 0;
	int accepted = 0;
	int answered = 0;
	int hits = 0;
	int waits = 0;
	int hold_off = 0;
	bit stimulus_done = 0;
	// Set by the monitor at the accepting rising edge, consumed at the next falling edge.
	bit req_taken = 0;
	bit rsp_taken = 0;

	function automatic void issue(ref rsp_t r, input int b);
		r.request_device = pool_dev[b];
		r.request_sector = 33'(pool_blk[b]) * 33'(SPB);
	endfunction

	function automatic rsp_t predict_cache(req_t q);
		rsp_t r;
		int b;
		bit hit;
		r = '0;
		b = 0;
		hit = 0;
		if (q.kind == K_GET || q.kind == K_READ) begin
			for (int i = 0; i < NBUF; i++)
				if (!hit && pool_mapped[i] && pool_dev[i] == q.device
						&& pool_blk[i] == q.block_number) begin
					b = i;
					hit = 1;
				end
			if (hit) begin
				r.handle = 4'(b);
				r.was_hit = 1'b1;
				if (pool_refs[b] == 8'd255) begin
					r.status = ST_OVF;
					return r;
				end
				if (pool_refs[b] == 0)
					foreach (lru_list[k])
						if (lru_list[k] == b) begin
							lru_list.delete(k);
							break;
						end
				pool_refs[b]++;
			end else begin
				if (used_count < NBUF) begin
					b = used_count;
					used_count++;
				end else if (lru_list.size() > 0) begin
					b = lru_list.pop_front();
				end else begin
					r.status = ST_WAIT;
					return r;
				end
				pool_dev[b] = q.device;
				pool_blk[b] = q.block_number;
				pool_mapped[b] = 1'b1;
				pool_valid[b] = 1'b0;
				pool_dirty[b] = 1'b0;
				pool_refs[b] = 8'd1;
				r.handle = 4'(b);
			end
			if (q.kind == K_READ && !pool_valid[b]) begin
				r.read_request = 1'b1;
				issue(r, b);
				pool_dirty[b] = 1'b0;
				pool_valid[b] = 1'b1;
			end
			return r;
		end
		b = q.buffer_index;
		r.handle = q.buffer_index;
		if (b >= NBUF || pool_refs[b] == 0) begin
			r.status = ST_BAD;
			return r;
		end
		if (q.modified)
			pool_dirty[b] = 1'b1;
		if (pool_dirty[b]) begin
			r.write_request = 1'b1;
			issue(r, b);
			pool_dirty[b] = 1'b0;
			pool_valid[b] = 1'b1;
		end
		if (q.kind == K_RELEASE) begin
			pool_refs[b]--;
			if (pool_refs[b] == 0 && lru_list.size() < NBUF)
				lru_list.push_back(b);
		end
		return r;
	endfunction

	function automatic req_t make_req(kind_t k, logic [7:0] d, logic [31:0] blk,
			logic [3:0] h, logic m);
		req_t q;
		q.kind = k;
		q.device = d;
		q.block_number = blk;
		q.buffer_index = h;
		q.modified = m;
		return q;
	endfunction

	// Random transaction over a small tag set so that hits, evictions and waits all happen.
	function automatic req_t random_req();
		req_t q;
		q.kind = kind_t'($urandom_range(0, 3));
		q.device = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2));
		q.block_number = ($urandom_range(0, 9) == 0) ? $urandom
			: 32'($urandom_range(0, 23)) ^ {32{$urandom_range(0, 7) == 0}};
		q.buffer_index = 4'($urandom);
		q.modified = 1'($urandom);
		return q;
	endfunction

	// Driver: changes inputs at the falling edge only.
	int send_gap = 0;
	always @(negedge clk) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.data <= '0;
		end else if (req_taken) begin
			// Accepted on the last rising edge; dropped here or replaced below.
			req_taken = 0;
			pending_reqs.pop_front();
			send_gap = $urandom_range(0, 2) == 0 ? $urandom_range(0, 14) : 0;
			if (send_gap == 0 && pending_reqs.size() > 0) begin
				req.data <= pending_reqs[0];
			end else begin
				req.valid <= 1'b0;
			end
		end else if (!req.valid) begin
			if (send_gap > 0)
				send_gap--;
			else if (pending_reqs.size() > 0) begin
				req.valid <= 1'b1;
				req.data <= pending_reqs[0];
			end
		end
	end

	// Receiver back-pressure, drawn per transaction at the falling edge.
	int recv_gap = 0;
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off--;
			rsp.ready <= 1'b0;
		end else if (rsp_taken) begin
			rsp_taken = 0;
			recv_gap = $urandom_range(0, 2) == 0 ? $urandom_range(0, 14) : 0;
			rsp.ready <= (recv_gap == 0);
		end else if (recv_gap > 0) begin
			recv_gap--;
			rsp.ready <= (recv_gap == 0);
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	// Monitor: predicts on accepted requests, checks accepted responses.
	always @(posedge clk) begin
		rsp_t e;
		rsp_t a;
		cycles++;
		if (arst_n) begin
			if (req.valid && req.ready) begin
				e = predict_cache(req.data);
				expected_rsps.push_back(e);
				accepted++;
				req_taken = 1;
			end
			if (rsp.valid && rsp.ready) begin
				a = rsp.data;
				answered++;
				rsp_taken = 1;
				if (expected_rsps.size() == 0) begin
					$error("response with no request outstanding");
					errors++;
				end else begin
					e = expected_rsps.pop_front();
					if (a.was_hit) hits++;
					if (a.status == ST_WAIT) waits++;
					if (a.status !== e.status) begin
						$error("status: expected %0d, actual %0d", e.status, a.status);
						errors++;
					end
					if (a.handle !== e.handle) begin
						$error("handle: expected %0d, actual %0d", e.handle, a.handle);
						errors++;
					end
					if (a.was_hit !== e.was_hit) begin
						$error("was_hit: expected %0b, actual %0b", e.was_hit, a.was_hit);
						errors++;
					end
					if (a.read_request !== e.read_request) begin
						$error("read_request: expected %0b, actual %0b",
							e.read_request, a.read_request);
						errors++;
					end
					if (a.write_request !== e.write_request) begin
						$error("write_request: expected %0b, actual %0b",
							e.write_request, a.write_request);
						errors++;
					end
					if (a.request_device !== e.request_device) begin
						$error("request_device: expected %0h, actual %0h",
							e.request_device, a.request_device);
						errors++;
					end
					if (a.request_sector !== e.request_sector) begin
						$error("request_sector: expected %0h, actual %0h",
							e.request_sector, a.request_sector);
						errors++;
					end
				end
			end
		end
		if (cycles >= LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		req.valid = 1'b0;
		req.data = '0;
		rsp.ready = 1'b0;
		used_count = 0;
		for (int i = 0; i < NBUF; i++) begin
			pool_refs[i] = 0;
			pool_dirty[i] = 0;
			pool_valid[i] = 0;
			pool_mapped[i] = 0;
		end
		// Directed part: extremes, every kind, bad handles, write back with modified.
		pending_reqs.push_back(make_req(K_RELEASE, 8'd0, 32'd0, 4'd0, 1'b0));
		pending_reqs.push_back(make_req(K_WRITE, 8'd0, 32'd0, 4'd15, 1'b1));
		pending_reqs.push_back(make_req(K_READ, 8'hFF, 32'hFFFF_FFFF, 4'd0, 1'b0));
		pending_reqs.push_back(make_req(K_GET, 8'hFF, 32'hFFFF_FFFF, 4'd0, 1'b0));
		pending_reqs.push_back(make_req(K_READ, 8'hFF, 32'hFFFF_FFFF, 4'd0, 1'b0));
		pending_reqs.push_back(make_req(K_GET, 8'h00, 32'h0, 4'd0, 1'b0));
		pending_reqs.push_back(make_req(K_WRITE, 8'd0, 32'd0, 4'd1, 1'b1));
		pending_reqs.push_back(make_req(K_WRITE, 8'd0, 32'd0, 4'd1, 1'b0));
		pending_reqs.push_back(make_req(K_RELEASE, 8'd0, 32'd0, 4'd1, 1'b1));
		pending_reqs.push_back(make_req(K_RELEASE, 8'd0, 32'd0, 4'd1, 1'b0));
		pending_reqs.push_back(make_req(K_READ, 8'h00, 32'h0, 4'd0, 1'b0));
		// Exhaust the pool so that the next miss has to wait.
		for (int i = 0; i < 15; i++)
			pending_reqs.push_back(make_req(K_GET, 8'h5A, 32'(1000 + i), 4'd0, 1'b0));
		pending_reqs.push_back(make_req(K_GET, 8'hA5, 32'h8000_0000, 4'd0, 1'b0));
		// Count overflow on one buffer, then release it back down.
		for (int i = 0; i < 256; i++)
			pending_reqs.push_back(make_req(K_GET, 8'h5A, 32'd1000, 4'd0, 1'b0));
		for (int i = 0; i < 256; i++)
			pending_reqs.push_back(make_req(K_RELEASE, 8'd0, 32'd0, 4'd2, 1'($urandom)));
		for (int i = 0; i < 16; i++)
			pending_reqs.push_back(make_req(K_RELEASE, 8'd0, 32'd0, 4'(i), 1'b1));
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// Long receiver hold-off while the sender keeps offering.
		repeat (3) @(negedge clk);
		hold_off = 300;
		for (int i = 0; i < 1045; i++)
			pending_reqs.push_back(random_req());
		while (pending_reqs.size() > 0) @(posedge clk);
		stimulus_done = 1;
		while (expected_rsps.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("Covered %0d transactions, %0d answered, %0d hits, %0d waits.",
			accepted, answered, hits, waits);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/bbcm_pkg.sv
rtl/bbcm_req_if.sv
rtl/bbcm_rsp_if.sv
rtl/bbcm_ctrl.sv
rtl/bbcm_dp.sv
rtl/block_buffer_cache_manager.sv
tb/block_buffer_cache_manager_test.sv
